>>> src/mee_pkg.sv
// Shared types, widths and the pair-ordering helper for the mesh edge extractor.
package mee_pkg;

    localparam int VTX_W      = 5;
    localparam int EDGE_IDX_W = 6;

    typedef struct packed {
        logic [VTX_W-1:0] lo;
        logic [VTX_W-1:0] hi;
    } pair_t;

    typedef struct packed {
        logic                  last_result;
        logic                  overflow;
        logic [EDGE_IDX_W-1:0] edge_index;
        logic [VTX_W-1:0]      high_vertex;
        logic [VTX_W-1:0]      low_vertex;
    } result_t;

    // Order two vertex indices low/high.
    function automatic pair_t order_pair(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
        pair_t p;
        p.lo = (a < b) ? a : b;
        p.hi = (a < b) ? b : a;
        return p;
    endfunction

endpackage

>>> src/mee_bitmap.sv
// Seen-pair bitmap: one row per low vertex, two registered read ports, one write port.
module mee_bitmap #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> src/mee_ctrl.sv
// Sequencer: face tracking, bitmap read-modify-write, edge counting and clearing sweep.
module mee_ctrl import mee_pkg::*; #(
    parameter int VERTEX_LIMIT = 32,
    parameter int EDGE_LIMIT   = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [VTX_W-1:0]                in_vertex,
    input  logic                            in_face_end,
    input  logic                            in_mesh_end,
    output logic                            rd_en,
    output logic [$clog2(VERTEX_LIMIT)-1:0] rd_addr_a,
    output logic [$clog2(VERTEX_LIMIT)-1:0] rd_addr_b,
    input  logic [VERTEX_LIMIT-1:0]         rd_data_a,
    input  logic [VERTEX_LIMIT-1:0]         rd_data_b,
    output logic                            wr_en,
    output logic [$clog2(VERTEX_LIMIT)-1:0] wr_addr,
    output logic [VERTEX_LIMIT-1:0]         wr_data,
    output logic                            res_valid,
    output result_t                         res,
    input  logic                            res_ready
);

    localparam int ROW_W = $clog2(VERTEX_LIMIT);
    localparam int CNT_W = $clog2(EDGE_LIMIT + 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(VERTEX_LIMIT - 1);
    localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(EDGE_LIMIT);
    localparam logic [8:0]       VLIM      = 9'(VERTEX_LIMIT);

    typedef logic [VERTEX_LIMIT-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [VTX_W-1:0]  first_reg, first_next;
    logic [VTX_W-1:0]  prev_reg, prev_next;
    logic              open_reg, open_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    pair_t             pair_a_reg, pair_a_next;
    pair_t             pair_b_reg, pair_b_next;
    logic              val_a_reg, val_a_next;
    logic              val_b_reg, val_b_next;
    logic              mend_reg, mend_next;
    logic              act_b_reg, act_b_next;
    logic              mark_a_reg, mark_a_next;
    logic              mark_b_reg, mark_b_next;
    result_t           res_a_reg, res_a_next;
    result_t           res_b_reg, res_b_next;
    row_t              wdata_a_reg, wdata_a_next;
    row_t              wdata_b_reg, wdata_b_next;

    // Lookup terms, valid in ST_LOOK
    pair_t             pair0, pair1;
    logic [VTX_W-1:0]  first_eff;
    logic [ROW_W-1:0]  hi_a, hi_b;
    logic              in_a, in_b, new_a, new_b, full_a, full_b, mark_a, mark_b;
    logic [CNT_W-1:0]  count_b;
    row_t              row_a_new, row_b_base, row_b_new;
    logic              accept, done_state;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign first_eff = open_reg ? first_reg : in_vertex;
    assign pair0     = order_pair(prev_reg, in_vertex);
    assign pair1     = order_pair(in_vertex, first_eff);

    assign rd_en     = accept;
    assign rd_addr_a = ROW_W'(pair0.lo);
    assign rd_addr_b = ROW_W'(pair1.lo);

    // Decide both pairs at once; the second sees the first's mark and count
    always_comb begin
        hi_a       = ROW_W'(pair_a_reg.hi);
        hi_b       = ROW_W'(pair_b_reg.hi);
        in_a       = val_a_reg && ({4'd0, pair_a_reg.hi} < VLIM);
        in_b       = val_b_reg && ({4'd0, pair_b_reg.hi} < VLIM);
        new_a      = in_a && !rd_data_a[hi_a];
        full_a     = (count_reg >= LIMIT_CNT);
        mark_a     = new_a && !full_a;
        row_a_new  = rd_data_a | (mark_a ? (row_t'(1) << hi_a) : '0);
        row_b_base = (pair_a_reg.lo == pair_b_reg.lo) ? row_a_new : rd_data_b;
        new_b      = in_b && !row_b_base[hi_b];
        count_b    = count_reg + CNT_W'(mark_a);
        full_b     = (count_b >= LIMIT_CNT);
        mark_b     = new_b && !full_b;
        row_b_new  = row_b_base | (mark_b ? (row_t'(1) << hi_b) : '0);
    end

    assign done_state = 1'b0;

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        open_next    = open_reg;
        count_next   = count_reg;
        pair_a_next  = pair_a_reg;
        pair_b_next  = pair_b_reg;
        val_a_next   = val_a_reg;
        val_b_next   = val_b_reg;
        mend_next    = mend_reg;
        act_b_next   = act_b_reg;
        mark_a_next  = mark_a_reg;
        mark_b_next  = mark_b_reg;
        res_a_next   = res_a_reg;
        res_b_next   = res_b_reg;
        wdata_a_next = wdata_a_reg;
        wdata_b_next = wdata_b_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_row_reg;
        wr_data      = '0;
        res_valid    = 1'b0;
        res          = res_a_reg;

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                first_next   = '0;
                prev_next    = '0;
                open_next    = 1'b0;
                count_next   = '0;
                clr_row_next = clr_row_reg + ROW_W'(1);
                if (clr_row_reg == LAST_ROW) begin
                    clr_row_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    pair_a_next = pair0;
                    pair_b_next = pair1;
                    val_a_next  = open_reg;
                    val_b_next  = in_face_end;
                    mend_next   = in_mesh_end;
                    if (!open_reg) begin
                        first_next = in_vertex;
                    end
                    prev_next = in_vertex;
                    open_next = !in_face_end;
                    if (open_reg || in_face_end) begin
                        state_next = ST_LOOK;
                    end else if (in_mesh_end) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_LOOK: begin
                count_next             = count_b + CNT_W'(mark_b);
                act_b_next             = new_b;
                mark_a_next            = mark_a;
                mark_b_next            = mark_b;
                wdata_a_next           = row_a_new;
                wdata_b_next           = row_b_new;
                res_a_next.low_vertex  = pair_a_reg.lo;
                res_a_next.high_vertex = pair_a_reg.hi;
                res_a_next.edge_index  = full_a ? '0 : EDGE_IDX_W'(count_reg);
                res_a_next.overflow    = full_a;
                res_a_next.last_result = !new_b;
                res_b_next.low_vertex  = pair_b_reg.lo;
                res_b_next.high_vertex = pair_b_reg.hi;
                res_b_next.edge_index  = full_b ? '0 : EDGE_IDX_W'(count_b);
                res_b_next.overflow    = full_b;
                res_b_next.last_result = 1'b1;
                if (new_a) begin
                    state_next = ST_EMIT_A;
                end else if (new_b) begin
                    state_next = ST_EMIT_B;
                end else begin
                    state_next = mend_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            ST_EMIT_A: begin
                res_valid = 1'b1;
                res       = res_a_reg;
                wr_addr   = ROW_W'(pair_a_reg.lo);
                wr_data   = wdata_a_reg;
                if (res_ready) begin
                    wr_en = mark_a_reg;
                    if (act_b_reg) begin
                        state_next = ST_EMIT_B;
                    end else begin
                        state_next = mend_reg ? ST_CLEAR : ST_IDLE;
                    end
                end
            end
            ST_EMIT_B: begin
                res_valid = 1'b1;
                res       = res_b_reg;
                wr_addr   = ROW_W'(pair_b_reg.lo);
                wr_data   = wdata_b_reg;
                if (res_ready) begin
                    wr_en      = mark_b_reg;
                    state_next = mend_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            first_reg   <= '0;
            prev_reg    <= '0;
            open_reg    <= 1'b0;
            count_reg   <= '0;
            val_a_reg   <= 1'b0;
            val_b_reg   <= 1'b0;
            mend_reg    <= 1'b0;
            act_b_reg   <= 1'b0;
            mark_a_reg  <= 1'b0;
            mark_b_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            first_reg   <= first_next;
            prev_reg    <= prev_next;
            open_reg    <= open_next;
            count_reg   <= count_next;
            val_a_reg   <= val_a_next;
            val_b_reg   <= val_b_next;
            mend_reg    <= mend_next;
            act_b_reg   <= act_b_next || done_state;
            mark_a_reg  <= mark_a_next;
            mark_b_reg  <= mark_b_next;
        end
        pair_a_reg  <= pair_a_next;
        pair_b_reg  <= pair_b_next;
        res_a_reg   <= res_a_next;
        res_b_reg   <= res_b_next;
        wdata_a_reg <= wdata_a_next;
        wdata_b_reg <= wdata_b_next;
    end

endmodule

>>> src/mesh_edge_extractor.sv
// Mesh edge extractor top level: input channel, sequencer, seen-pair bitmap, output register.
// First result: a vertex transfer passes ST_LOOK, an emit state and the output register,
//   if the output is free. A vertex that forms no pair keeps s_tready high; otherwise ST_LOOK
//   and one emit state per new edge (up to two) hold it low, as the bitmap has a single write
//   port and the output register holds one result. Reset: synchronous, active low; then a
//   sweep clears all VERTEX_LIMIT rows, one bitmap row a cycle, s_tready low; every mesh_end too.
module mesh_edge_extractor import mee_pkg::*; #(
    parameter int VERTEX_LIMIT = 32,
    parameter int EDGE_LIMIT   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] vertex, [7:5] zero
    input  logic        s_tlast,   // face_end
    input  logic [0:0]  s_tuser,   // [0] mesh_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] low_vertex, [9:5] high_vertex, [15:10] edge_index
    output logic        m_tlast,   // last_result
    output logic [0:0]  m_tuser    // [0] overflow
);

    localparam int ROW_W = $clog2(VERTEX_LIMIT);

    // Bitmap access between sequencer and memory
    logic                    bm_rd_en;
    logic [ROW_W-1:0]        bm_rd_addr_a;
    logic [ROW_W-1:0]        bm_rd_addr_b;
    logic [VERTEX_LIMIT-1:0] bm_rd_data_a;
    logic [VERTEX_LIMIT-1:0] bm_rd_data_b;
    logic                    bm_wr_en;
    logic [ROW_W-1:0]        bm_wr_addr;
    logic [VERTEX_LIMIT-1:0] bm_wr_data;

    // Result hand-off into the output register
    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    mee_ctrl #(
        .VERTEX_LIMIT (VERTEX_LIMIT),
        .EDGE_LIMIT   (EDGE_LIMIT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_vertex   (s_tdata[VTX_W-1:0]),
        .in_face_end (s_tlast),
        .in_mesh_end (s_tuser[0]),
        .rd_en       (bm_rd_en),
        .rd_addr_a   (bm_rd_addr_a),
        .rd_addr_b   (bm_rd_addr_b),
        .rd_data_a   (bm_rd_data_a),
        .rd_data_b   (bm_rd_data_b),
        .wr_en       (bm_wr_en),
        .wr_addr     (bm_wr_addr),
        .wr_data     (bm_wr_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    mee_bitmap #(
        .DEPTH (VERTEX_LIMIT),
        .WIDTH (VERTEX_LIMIT)
    ) u_bitmap (
        .aclk      (aclk),
        .rd_en     (bm_rd_en),
        .rd_addr_a (bm_rd_addr_a),
        .rd_addr_b (bm_rd_addr_b),
        .rd_data_a (bm_rd_data_a),
        .rd_data_b (bm_rd_data_b),
        .wr_en     (bm_wr_en),
        .wr_addr   (bm_wr_addr),
        .wr_data   (bm_wr_data)
    );

    // Output register: take a new result when empty or when the current one transfers
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_data_reg.edge_index, out_data_reg.high_vertex,
                         out_data_reg.low_vertex};
    assign m_tlast    = out_data_reg.last_result;
    assign m_tuser[0] = out_data_reg.overflow;

    // Bitmap writes (sweep or mark) never coincide with an input transfer
    a_no_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready && bm_wr_en))
        else $error("bitmap write during input transfer");

    // An overflowed edge carries index zero
    a_overflow_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:10] == 6'd0))
        else $error("overflow result with non-zero edge index");

    // A mesh-end transfer always leaves the input stalled in the next cycle
    a_mesh_end_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("input ready straight after mesh end");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the mesh edge extractor: directed faces, then random meshes.
`timescale 1ns / 1ps

module tb import mee_pkg::*; ();

    // Edge model: tracks the seen-pair map and face state, and holds the edges still owed.
    class edge_scoreboard;
        bit [1023:0] seen_map;
        logic [4:0]  face_first;
        logic [4:0]  face_prev;
        bit          face_open;
        int unsigned edge_cnt;
        result_t     owed_edges[$];
        int          mismatches;
        int          edges_checked;
        int          overflows_checked;
        int          vertices_noted;
        int          meshes_noted;

        function new();
            mismatches = 0;
            edges_checked = 0;
            overflows_checked = 0;
            vertices_noted = 0;
            meshes_noted = 0;
            reset_mesh();
        endfunction

        function void reset_mesh();
            seen_map = '0;
            face_first = '0;
            face_prev = '0;
            face_open = 1'b0;
            edge_cnt = 0;
        endfunction

        // Order one pair, look it up and mark it unless the edge store is full; returns 1 when an edge is owed.
        function bit take_pair(input logic [4:0] a, input logic [4:0] b, output result_t r);
            logic [4:0] lo;
            logic [4:0] hi;
            int         slot;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            slot = int'(lo) * 32 + int'(hi);
            r = '0;
            if (seen_map[slot])
                return 1'b0;
            r.low_vertex = lo;
            r.high_vertex = hi;
            if (edge_cnt >= 64) begin
                r.overflow = 1'b1;
                return 1'b1;
            end
            seen_map[slot] = 1'b1;
            r.edge_index = edge_cnt[5:0];
            edge_cnt++;
            return 1'b1;
        endfunction

        function void note_vertex(input logic [4:0] v, input logic fend, input logic mend);
            result_t r [2];
            int      n;
            n = 0;
            vertices_noted++;
            if (!face_open) begin
                face_first = v;
                face_open = 1'b1;
            end else if (take_pair(face_prev, v, r[n])) begin
                n++;
            end
            face_prev = v;
            if (fend) begin
                if (take_pair(v, face_first, r[n]))
                    n++;
                face_open = 1'b0;
            end
            if (n > 0)
                r[n-1].last_result = 1'b1;
            for (int i = 0; i < n; i++)
                owed_edges.push_back(r[i]);
            if (mend) begin
                meshes_noted++;
                reset_mesh();
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (owed_edges.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected edge: lo=%0d hi=%0d idx=%0d ovf=%0b last=%0b",
                             $time, got.low_vertex, got.high_vertex, got.edge_index,
                             got.overflow, got.last_result);
                return;
            end
            want = owed_edges.pop_front();
            edges_checked++;
            if (want.overflow)
                overflows_checked++;
            if (got.low_vertex !== want.low_vertex || got.high_vertex !== want.high_vertex ||
                got.edge_index !== want.edge_index || got.overflow !== want.overflow ||
                got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] edge mismatch: expected lo=%0d hi=%0d idx=%0d ovf=%0b ",
                              "last=%0b, got lo=%0d hi=%0d idx=%0d ovf=%0b last=%0b"},
                             $time, want.low_vertex, want.high_vertex, want.edge_index,
                             want.overflow, want.last_result, got.low_vertex,
                             got.high_vertex, got.edge_index, got.overflow, got.last_result);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    edge_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;

    mesh_edge_extractor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Check each result transfer, then pick the next ready level.
    always @(posedge aclk) begin
        result_t got;
        got.low_vertex = m_tdata[4:0];
        got.high_vertex = m_tdata[9:5];
        got.edge_index = m_tdata[15:10];
        got.overflow = m_tuser[0];
        got.last_result = m_tlast;
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(got);
        m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Offer one vertex after a random gap; hold it until the transfer, then note it.
    task automatic send_vertex(input logic [4:0] v, input logic fend, input logic mend);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, v};
        s_tlast <= fend;
        s_tuser <= mend;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_vertex(v, fend, mend);
    endtask

    // One mesh of random faces drawn from a window of the vertex range; the last item ends it.
    task automatic send_mesh(input int n_items, input int pool, input int max_face);
        int         face_len;
        int         pos;
        logic [4:0] base;
        logic [4:0] v;
        logic       fend;
        logic       mend;
        face_len = $urandom_range(max_face, 1);
        pos = 0;
        base = 5'($urandom_range(31, 0));
        for (int k = 0; k < n_items; k++) begin
            v = base + 5'($urandom_range(pool - 1, 0));
            pos++;
            fend = (pos >= face_len);
            mend = (k == n_items - 1);
            // Break the face shape now and then: early or late close, or mesh end with the face open.
            if ($urandom_range(19, 0) == 0)
                fend = ~fend;
            if (mend && !fend && $urandom_range(1, 0) == 1)
                fend = 1'b1;
            send_vertex(v, fend, mend);
            if (fend) begin
                pos = 0;
                face_len = $urandom_range(max_face, 1);
            end
        end
    endtask

    initial begin
        int sent_before;
        int idle_tab  [4] = '{0, 79, 0, 38};
        int stall_tab [4] = '{0, 0, 79, 38};

        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: triangle, the same triangle reversed (all pairs seen), single-vertex
        // faces at both ends of the range, alternating bit patterns, mesh end inside an
        // open face, then a fresh mesh that closes and ends on one transfer.
        send_vertex(5'd0, 1'b0, 1'b0);
        send_vertex(5'd1, 1'b0, 1'b0);
        send_vertex(5'd2, 1'b1, 1'b0);
        send_vertex(5'd2, 1'b0, 1'b0);
        send_vertex(5'd1, 1'b0, 1'b0);
        send_vertex(5'd0, 1'b1, 1'b0);
        send_vertex(5'd31, 1'b1, 1'b0);
        send_vertex(5'd0, 1'b1, 1'b0);
        send_vertex(5'd21, 1'b0, 1'b0);
        send_vertex(5'd10, 1'b0, 1'b0);
        send_vertex(5'd31, 1'b1, 1'b0);
        send_vertex(5'd5, 1'b0, 1'b0);
        send_vertex(5'd6, 1'b0, 1'b1);
        send_vertex(5'd0, 1'b0, 1'b0);
        send_vertex(5'd31, 1'b0, 1'b0);
        send_vertex(5'd1, 1'b1, 1'b1);

        // Random meshes in four idling phases; open each phase with a long mesh so the
        // edge store fills and overflow results appear.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            sent_before = sb.vertices_noted;
            send_mesh($urandom_range(200, 150), 32, 6);
            while (sb.vertices_noted - sent_before < 240) begin
                if ($urandom_range(7, 0) == 0)
                    send_mesh($urandom_range(160, 100), $urandom_range(32, 12), 8);
                else
                    send_mesh($urandom_range(40, 1), $urandom_range(32, 2), 8);
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // Drain owed edges, then watch a little longer for strays.
        while (sb.owed_edges.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d vertices in %0d meshes; checked %0d edges, %0d of them overflow.",
                 sb.vertices_noted, sb.meshes_noted, sb.edges_checked, sb.overflows_checked);
        $display("Idling phases: none, sender 79%%, receiver 79%%, both 38%%; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_edges.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d edges still owed", sb.owed_edges.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
src/mee_pkg.sv
src/mee_bitmap.sv
src/mee_ctrl.sv
src/mesh_edge_extractor.sv
sim/tb.sv
